[sv/olist_pkg.sv]
`timescale 1ns / 1ps
package olist_pkg;
	localparam int CAPACITY_DEF = 32;
	localparam int MAX_DUMP = 32;

	typedef enum logic [3:0] {
		OP_INS_HEAD = 4'd0, OP_INS_TAIL = 4'd1, OP_INS_POS = 4'd2,
		OP_DEL_HEAD = 4'd3, OP_DEL_TAIL = 4'd4, OP_DEL_POS = 4'd5,
		OP_REVERSE = 4'd6, OP_SEARCH = 4'd7, OP_DUMP = 4'd8, OP_CLEAR = 4'd9
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_INVALID = 3'd2,
		ST_FULL = 3'd3, ST_FOUND = 3'd4, ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SHIFT_UP, S_UP_WR, S_WRITE, S_READ_DEL, S_SHIFT_DN, S_DN_WR,
		S_REV, S_REV_WI, S_REV_WJ, S_SEARCH, S_SCMP, S_DUMP_RD, S_DUMP_OUT, S_OUT
	} state_t;

	// Memory operations issued by the controller.
	typedef enum logic [3:0] {
		M_NONE, M_RD_I, M_RD_IM1, M_RD_IP1, M_RD_IJ,
		M_WR_I_RD, M_WR_I_VAL, M_WR_I_TMP, M_WR_J_RD
	} mop_t;

	typedef struct packed {
		logic    load;      // capture the input item
		mop_t    mop;
		logic    i_inc;
		logic    i_dec;
		logic    j_dec;
		logic    set_i_ins; // i = count, j = target index
		logic    set_i_del; // i = target index
		logic    set_rev;   // i = 0, j = count-1
		logic    set_zero;  // i = 0
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
		logic    save_elem; // element register takes the entry at i
		logic    set_status;
		status_t status;
		logic    dump_out;  // result carries the entry read for a dump
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    pos_zero;
		logic    full;
		logic    empty;
		logic    i_gt_j;   // shift up still has work
		logic    i_end;    // i+1 >= count (shift down / dump / search end)
		logic    i_lt_j;   // reverse still has work
		logic    dump_end; // final element of a dump
		logic    match;
	} sts_t;
endpackage

[sv/olist_if.sv]
`timescale 1ns / 1ps
interface olist_in_if;
	logic                valid;
	logic                ready;
	logic [3:0]          opcode;
	logic signed [31:0]  value;
	logic [7:0]          position;
	modport source (output valid, opcode, value, position, input ready);
	modport sink (input valid, opcode, value, position, output ready);
endinterface

interface olist_out_if;
	logic                valid;
	logic                ready;
	logic [2:0]          status;
	logic signed [31:0]  element;
	logic [5:0]          count;
	logic                last_of_run;
	modport source (output valid, status, element, count, last_of_run, input ready);
	modport sink (input valid, status, element, count, last_of_run, output ready);
endinterface

[sv/olist_datapath.sv]
`timescale 1ns / 1ps
module olist_datapath #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  olist_pkg::cmd_t    cmd,
	output olist_pkg::sts_t    sts,
	input  logic [3:0]         in_opcode,
	input  logic [31:0]        in_value,
	input  logic [7:0]         in_position,
	output logic [2:0]         res_status,
	output logic [31:0]        res_element,
	output logic [5:0]         res_count
);
	import olist_pkg::*;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rd_q, tmp_q, val_q, elem_q;
	logic [3:0]    op_q;
	logic [7:0]    pos_q;
	logic [CW-1:0] cnt_q, i_q, j_q, tgt, i_m1, i_p1;
	logic [8:0]    pos_m1;
	logic [2:0]    status_q;

	assign i_m1 = i_q - CW'(1);
	assign i_p1 = i_q + CW'(1);
	assign pos_m1 = {1'b0, pos_q} - 9'd1;

	// Target index of a positional operation, clamped to the list.
	always_comb begin
		tgt = '0;
		case (opcode_t'(op_q))
			OP_INS_HEAD, OP_DEL_HEAD: tgt = '0;
			OP_INS_TAIL: tgt = cnt_q;
			OP_DEL_TAIL: tgt = cnt_q - CW'(1);
			OP_INS_POS: tgt = (pos_m1 > 9'(cnt_q)) ? cnt_q : CW'(pos_m1);
			OP_DEL_POS: tgt = (pos_m1 >= 9'(cnt_q)) ? cnt_q - CW'(1) : CW'(pos_m1);
			default: tgt = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_opcode;
			val_q <= in_value;
			pos_q <= in_position;
			elem_q <= '0;
		end
		case (cmd.mop)
			M_RD_I: rd_q <= mem[i_q[AW-1:0]];
			M_RD_IM1: rd_q <= mem[i_m1[AW-1:0]];
			M_RD_IP1: rd_q <= mem[i_p1[AW-1:0]];
			M_RD_IJ: begin
				rd_q <= mem[i_q[AW-1:0]];
				tmp_q <= mem[j_q[AW-1:0]];
			end
			M_WR_I_RD: mem[i_q[AW-1:0]] <= rd_q;
			M_WR_I_VAL: mem[i_q[AW-1:0]] <= val_q;
			M_WR_I_TMP: mem[i_q[AW-1:0]] <= tmp_q;
			M_WR_J_RD: mem[j_q[AW-1:0]] <= rd_q;
			default: ;
		endcase
		if (cmd.save_elem) elem_q <= mem[i_q[AW-1:0]];
		if (cmd.set_status) status_q <= cmd.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			else if (cmd.cnt_dec) cnt_q <= cnt_q - CW'(1);
			if (cmd.set_i_ins) begin
				i_q <= cnt_q;
				j_q <= tgt;
			end else if (cmd.set_i_del) i_q <= tgt;
			else if (cmd.set_rev) begin
				i_q <= '0;
				j_q <= cnt_q - CW'(1);
			end else if (cmd.set_zero) i_q <= '0;
			else begin
				if (cmd.i_inc) i_q <= i_p1;
				else if (cmd.i_dec) i_q <= i_m1;
				if (cmd.j_dec) j_q <= j_q - CW'(1);
			end
		end
	end

	always_comb begin
		sts.op = opcode_t'(op_q);
		sts.pos_zero = (pos_q == 8'd0);
		sts.full = (cnt_q >= CW'(CAPACITY));
		sts.empty = (cnt_q == '0);
		sts.i_gt_j = (i_q > j_q);
		sts.i_end = (({1'b0, i_q} + (CW+1)'(1)) >= {1'b0, cnt_q});
		sts.i_lt_j = (i_q < j_q) && (cnt_q != '0);
		sts.dump_end = sts.i_end || ((32'(i_q) + 32'd1) >= 32'(MAX_DUMP));
		sts.match = (rd_q == val_q);
	end

	assign res_status = cmd.dump_out ? ST_OK : status_q;
	assign res_element = cmd.dump_out ? rd_q : elem_q;
	assign res_count = 6'(cnt_q);
endmodule

[sv/olist_ctrl.sv]
`timescale 1ns / 1ps
module olist_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_last,
	output olist_pkg::cmd_t cmd,
	input  olist_pkg::sts_t sts
);
	import olist_pkg::*;
	state_t state_q, state_d;
	logic   last_q, last_d;

	always_comb begin
		state_d = state_q;
		last_d = last_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				case (sts.op)
					OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
						if ((sts.op == OP_INS_POS && sts.pos_zero) || sts.full) state_d = S_OUT;
						else state_d = S_SHIFT_UP;
					OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS:
						if (sts.empty || (sts.op == OP_DEL_POS && sts.pos_zero)) state_d = S_OUT;
						else state_d = S_READ_DEL;
					OP_REVERSE: state_d = S_REV;
					OP_SEARCH: state_d = sts.empty ? S_OUT : S_SEARCH;
					OP_DUMP: state_d = sts.empty ? S_OUT : S_DUMP_RD;
					default: state_d = S_OUT;
				endcase
			end
			S_SHIFT_UP: state_d = sts.i_gt_j ? S_UP_WR : S_WRITE;
			S_UP_WR: state_d = S_SHIFT_UP;
			S_WRITE: state_d = S_OUT;
			S_READ_DEL: state_d = S_SHIFT_DN;
			S_SHIFT_DN: state_d = sts.i_end ? S_OUT : S_DN_WR;
			S_DN_WR: state_d = S_SHIFT_DN;
			S_REV: state_d = sts.i_lt_j ? S_REV_WI : S_OUT;
			S_REV_WI: state_d = S_REV_WJ;
			S_REV_WJ: state_d = S_REV;
			S_SEARCH: state_d = S_SCMP;
			S_SCMP: state_d = (sts.match || sts.i_end) ? S_OUT : S_SEARCH;
			S_DUMP_RD: begin
				state_d = S_DUMP_OUT;
				last_d = sts.dump_end;
			end
			S_DUMP_OUT: if (out_ready) state_d = last_q ? S_IDLE : S_DUMP_RD;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mop = M_NONE;
		cmd.status = ST_OK;
		in_ready = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT) || (state_q == S_DUMP_OUT);
		out_last = (state_q == S_OUT) || ((state_q == S_DUMP_OUT) && last_q);
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_DECODE: begin
				cmd.set_status = 1'b1;
				case (sts.op)
					OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
						if (sts.op == OP_INS_POS && sts.pos_zero) cmd.status = ST_INVALID;
						else if (sts.full) cmd.status = ST_FULL;
						cmd.set_i_ins = 1'b1;
					end
					OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
						if (sts.empty) cmd.status = ST_EMPTY;
						else if (sts.op == OP_DEL_POS && sts.pos_zero) cmd.status = ST_INVALID;
						cmd.set_i_del = 1'b1;
					end
					OP_REVERSE: cmd.set_rev = 1'b1;
					OP_SEARCH: begin
						cmd.status = ST_NOT_FOUND;
						cmd.set_zero = 1'b1;
					end
					OP_DUMP: begin
						cmd.status = ST_EMPTY;
						cmd.set_zero = 1'b1;
					end
					OP_CLEAR: cmd.cnt_clr = 1'b1;
					default: ;
				endcase
			end
			// Move entries up one place, from the tail down to the target.
			S_SHIFT_UP: if (sts.i_gt_j) cmd.mop = M_RD_IM1;
			S_UP_WR: begin
				cmd.mop = M_WR_I_RD;
				cmd.i_dec = 1'b1;
			end
			S_WRITE: begin
				cmd.mop = M_WR_I_VAL;
				cmd.cnt_inc = 1'b1;
			end
			S_READ_DEL: cmd.save_elem = 1'b1;
			// Move entries down one place, from the target up to the tail.
			S_SHIFT_DN: begin
				if (sts.i_end) cmd.cnt_dec = 1'b1;
				else cmd.mop = M_RD_IP1;
			end
			S_DN_WR: begin
				cmd.mop = M_WR_I_RD;
				cmd.i_inc = 1'b1;
			end
			S_REV: if (sts.i_lt_j) cmd.mop = M_RD_IJ;
			S_REV_WI: cmd.mop = M_WR_I_TMP;
			S_REV_WJ: begin
				cmd.mop = M_WR_J_RD;
				cmd.i_inc = 1'b1;
				cmd.j_dec = 1'b1;
			end
			S_SEARCH: cmd.mop = M_RD_I;
			S_SCMP: begin
				if (sts.match) begin
					cmd.set_status = 1'b1;
					cmd.status = ST_FOUND;
				end else if (!sts.i_end) cmd.i_inc = 1'b1;
			end
			S_DUMP_RD: cmd.mop = M_RD_I;
			S_DUMP_OUT: begin
				cmd.dump_out = 1'b1;
				if (out_ready) cmd.i_inc = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q <= (state_q == S_IDLE) ? 1'b0 : last_d;
		end
	end
endmodule

[sv/olist_core.sv]
`timescale 1ns / 1ps
// Joins the controller and the datapath and ties them to the item channels.
module olist_core #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	olist_in_if.sink    in_ch,
	olist_out_if.source out_ch
);
	import olist_pkg::*;

	cmd_t cmd;
	sts_t sts;

	olist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_last  (out_ch.last_of_run),
		.cmd       (cmd),
		.sts       (sts)
	);

	olist_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_opcode   (in_ch.opcode),
		.in_value    (in_ch.value),
		.in_position (in_ch.position),
		.res_status  (out_ch.status),
		.res_element (out_ch.element),
		.res_count   (out_ch.count)
	);
endmodule

[sv/ordered_list_engine_unit.sv]
`timescale 1ns / 1ps
// Bounded ordered list of up to CAPACITY signed 32-bit values held in a
// register memory that is read at one or two addresses a cycle. An item
// carries an opcode (insert at head, tail or position; delete at head, tail
// or position; reverse; search; dump; clear) and produces one result item,
// except a dump, which produces one result per element (up to 32) with
// last_of_run on the final one. The block takes one item at a time and takes
// the next only after the final result of the previous one has been accepted.
// Clear, an unused opcode, a rejected insert or delete, and a search or
// dump of an empty list finish without a walk over the list memory; an
// insert or a delete walks the entries that it moves, a reverse the pairs
// that it swaps, a search the entries that it compares and a dump its
// elements. The default capacity is 32. A receiver that holds off a
// result holds the block until the result is taken. Results are held
// stable on the output until taken.
module ordered_list_engine_unit #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	olist_in_if.sink    in_ch,
	olist_out_if.source out_ch
);
	import olist_pkg::*;

	olist_core #(.CAPACITY(CAPACITY)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);
endmodule

[sv/olist_checker.sv]
`timescale 1ns / 1ps
module olist_checker #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [5:0]  count,
	input logic        last_of_run
);
	import olist_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count} <= 7'(CAPACITY)) else $error("count beyond capacity");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_NOT_FOUND) else $error("bad status");
	a_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> status == ST_OK)
		else $error("run of results with a failing status");
endmodule

bind ordered_list_engine_unit olist_checker #(.CAPACITY(CAPACITY)) u_chk (
	.clk (clk), .arst_n (arst_n),
	.in_ready (in_ch.ready),
	.out_valid (out_ch.valid), .out_ready (out_ch.ready),
	.status (out_ch.status), .count (out_ch.count),
	.last_of_run (out_ch.last_of_run)
);

[dv/ordered_list_engine_unit_tb.sv]
`timescale 1ns / 1ps
import olist_pkg::*;

// One expected result item of the list engine.
typedef struct {
	logic [2:0]         status;
	logic signed [31:0] element;
	logic [5:0]         count;
	logic               last_of_run;
} list_result_t;

// Holds its own copy of the list and predicts the result items of every
// accepted item. Result items are compared in order against the oldest
// prediction.
class list_scoreboard;
	logic signed [31:0] elems[32];
	int unsigned        n_elems;
	list_result_t       pending_q[$];
	int unsigned        errors;
	int unsigned        checked;
	int unsigned        peak;
	int unsigned        full_hits;

	function new();
		n_elems = 0;
		errors = 0;
		checked = 0;
		peak = 0;
		full_hits = 0;
	endfunction

	function void push_result(logic [2:0] st, logic signed [31:0] el, logic last);
		list_result_t r;
		r.status = st;
		r.element = el;
		r.count = n_elems[5:0];
		r.last_of_run = last;
		pending_q.push_back(r);
	endfunction

	function logic [2:0] insert_at(int unsigned idx, logic signed [31:0] v);
		if (n_elems >= 32) begin
			full_hits++;
			return ST_FULL;
		end
		if (idx > n_elems)
			idx = n_elems;
		for (int unsigned i = n_elems; i > idx; i--)
			elems[i] = elems[i - 1];
		elems[idx] = v;
		n_elems++;
		if (n_elems > peak)
			peak = n_elems;
		return ST_OK;
	endfunction

	function logic signed [31:0] remove_at(int unsigned idx);
		logic signed [31:0] v;
		if (idx >= n_elems)
			idx = n_elems - 1;
		v = elems[idx];
		for (int unsigned i = idx; i + 1 < n_elems; i++)
			elems[i] = elems[i + 1];
		n_elems--;
		return v;
	endfunction

	// Notes one accepted input item and queues the result items it causes.
	function void note_item(logic [3:0] op, logic signed [31:0] v, logic [7:0] p);
		logic [2:0]         st;
		logic signed [31:0] el;
		logic signed [31:0] t;
		st = ST_OK;
		el = 0;
		case (op)
			OP_INS_HEAD: st = insert_at(0, v);
			OP_INS_TAIL: st = insert_at(n_elems, v);
			OP_INS_POS: begin
				if (p == 0)
					st = ST_INVALID;
				else
					st = insert_at(p - 1, v);
			end
			OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
				if (n_elems == 0)
					st = ST_EMPTY;
				else if (op == OP_DEL_HEAD)
					el = remove_at(0);
				else if (op == OP_DEL_TAIL)
					el = remove_at(n_elems - 1);
				else if (p == 0)
					st = ST_INVALID;
				else
					el = remove_at(p - 1);
			end
			OP_REVERSE: begin
				for (int unsigned i = 0; i < n_elems / 2; i++) begin
					t = elems[i];
					elems[i] = elems[n_elems - 1 - i];
					elems[n_elems - 1 - i] = t;
				end
			end
			OP_SEARCH: begin
				st = ST_NOT_FOUND;
				for (int unsigned i = 0; i < n_elems; i++)
					if (elems[i] == v)
						st = ST_FOUND;
			end
			OP_DUMP: begin
				if (n_elems == 0) begin
					st = ST_EMPTY;
				end else begin
					for (int unsigned i = 0; i < n_elems; i++)
						push_result(ST_OK, elems[i], i + 1 == n_elems);
					return;
				end
			end
			OP_CLEAR: n_elems = 0;
			default: ;
		endcase
		push_result(st, el, 1'b1);
	endfunction

	// Checks one accepted result item against the oldest prediction.
	function void check_result(list_result_t got);
		list_result_t want;
		checked++;
		if (pending_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result st=%0d el=%0d cnt=%0d last=%0b", $time,
				got.status, got.element, got.count, got.last_of_run);
			return;
		end
		want = pending_q.pop_front();
		if (got.status !== want.status) begin
			errors++;
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
		end
		if (got.element !== want.element) begin
			errors++;
			$display("%0t: element expected %0d actual %0d", $time, want.element,
				got.element);
		end
		if (got.count !== want.count) begin
			errors++;
			$display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
		end
		if (got.last_of_run !== want.last_of_run) begin
			errors++;
			$display("%0t: last_of_run expected %0b actual %0b", $time, want.last_of_run,
				got.last_of_run);
		end
	endfunction
endclass

module ordered_list_engine_unit_tb;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	int unsigned cycles = 0;
	// Idle pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both lightly.
	int unsigned idle_mode;
	int unsigned items_sent;

	olist_in_if  in_ch();
	olist_out_if out_ch();

	list_scoreboard sb;

	ordered_list_engine_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #10 clk = ~clk;

	// Watchdog: the slowest correct run is far below this bound.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("ordered_list_engine_unit_tb: done, errors");
			$finish;
		end
	end

	// Result side: every item taken is checked at the edge where it is
	// accepted, then ready is chosen for the next cycle by the idle pattern.
	always @(posedge clk) begin
		list_result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.status = out_ch.status;
			got.element = out_ch.element;
			got.count = out_ch.count;
			got.last_of_run = out_ch.last_of_run;
			sb.check_result(got);
		end
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else if (idle_mode == 2)
			out_ch.ready <= ($urandom_range(99) >= 76);
		else if (idle_mode == 3)
			out_ch.ready <= ($urandom_range(99) >= 13);
		else
			out_ch.ready <= 1'b1;
	end

	// Offers one item and holds it until the block takes it. Valid is left
	// high afterward so back-to-back items need no second assignment.
	task automatic send_item(logic [3:0] op, logic signed [31:0] v, logic [7:0] p);
		int unsigned gap_pct;
		gap_pct = (idle_mode == 1) ? 76 : (idle_mode == 3) ? 13 : 0;
		if ($urandom_range(99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.value <= v;
		in_ch.position <= p;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_item(op, v, p);
		items_sent++;
	endtask

	// Random item. Inserts dominate while fill_bias is set, deletes otherwise,
	// so the list swings between empty and full. Values often come from a
	// small pool so searches hit.
	task automatic send_random(bit fill_bias);
		logic [3:0]         op;
		logic signed [31:0] v;
		logic [7:0]         p;
		int unsigned        r;
		r = $urandom_range(99);
		if (r < 2)
			op = 4'($urandom_range(15, 10));
		else if (r < 5)
			op = OP_CLEAR;
		else if (r < 10)
			op = OP_DUMP;
		else if (r < 18)
			op = OP_SEARCH;
		else if (r < 23)
			op = OP_REVERSE;
		else if (r < (fill_bias ? 75 : 45))
			op = opcode_t'($urandom_range(2, 0));
		else
			op = opcode_t'($urandom_range(5, 3));
		v = ($urandom_range(1) == 0) ? $signed($urandom_range(7)) - 4 : $urandom();
		r = $urandom_range(7);
		if (r == 0)
			p = 8'd0;
		else if (r == 1)
			p = 8'($urandom());
		else
			p = 8'($urandom_range(sb.n_elems + 2, 1));
		send_item(op, v, p);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		idle_mode = 0;
		items_sent = 0;
		in_ch.valid = 1'b0;
		in_ch.opcode = 4'd0;
		in_ch.value = 32'sd0;
		in_ch.position = 8'd0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operations on the empty list, both value extremes,
		// position zero and position 255, then deletes of every kind.
		send_item(OP_DUMP, 0, 0);
		send_item(OP_DEL_HEAD, 0, 0);
		send_item(OP_DEL_TAIL, 0, 0);
		send_item(OP_DEL_POS, 0, 0);
		send_item(OP_SEARCH, 5, 0);
		send_item(OP_REVERSE, 0, 0);
		send_item(OP_CLEAR, 0, 0);
		send_item(OP_INS_HEAD, 32'sh7fffffff, 0);
		send_item(OP_INS_TAIL, 32'sh80000000, 0);
		send_item(OP_INS_POS, 17, 0);
		send_item(OP_INS_POS, 17, 1);
		send_item(OP_INS_POS, -1, 8'd255);
		send_item(OP_INS_POS, 3, 2);
		send_item(OP_DUMP, 0, 0);
		send_item(OP_SEARCH, 32'sh80000000, 0);
		send_item(OP_SEARCH, 99, 0);
		send_item(OP_REVERSE, 0, 0);
		send_item(OP_DUMP, 0, 0);
		send_item(OP_DEL_POS, 0, 0);
		send_item(OP_DEL_POS, 0, 8'd255);
		send_item(OP_DEL_POS, 0, 2);
		send_item(OP_DEL_HEAD, 0, 0);
		send_item(OP_DEL_TAIL, 0, 0);
		send_item(4'd15, 0, 0);
		send_item(OP_DEL_HEAD, 0, 0);

		// Fill the list until an insert is refused, walk it at full length,
		// then empty it.
		for (int k = 0; k < 33; k++)
			send_item(OP_INS_TAIL, k, 0);
		send_item(OP_DUMP, 0, 0);
		send_item(OP_REVERSE, 0, 0);
		send_item(OP_DEL_HEAD, 0, 0);
		send_item(OP_CLEAR, 0, 0);

		// Random phases, one per idle pattern, each filling then draining.
		for (int ph = 0; ph < 4; ph++) begin
			idle_mode = ph;
			for (int k = 0; k < 92; k++)
				send_random(k < 54);
		end
		in_ch.valid <= 1'b0;

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("%0d items sent, %0d result items checked, %0d inserts hit a full list",
			items_sent, sb.checked, sb.full_hits);
		$display("largest list held %0d elements", sb.peak);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("ordered_list_engine_unit_tb: done, clean");
		else
			$display("ordered_list_engine_unit_tb: done, errors");
		$finish;
	end
endmodule
